@@ sv/dense_layer_matrix_vector_core_defines.svh @@
// assertion macros shared by the dense layer core modules
`ifndef DENSE_LAYER_MATRIX_VECTOR_CORE_DEFINES_SVH
`define DENSE_LAYER_MATRIX_VECTOR_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DLMV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DLMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dlmv_pkg.sv @@
// shared types and constants for the dense layer matrix-vector core
package dlmv_pkg;

  localparam int VALUE_W   = 16;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 40;
  localparam int ROW_IDX_W = 5;
  localparam int COL_IDX_W = 2;
  localparam int RES_IDX_W = 2;

  // action codes of an input word
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_ELEM  = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic                 take;
    logic                 shift;
    logic                 final_word;
    logic [RES_IDX_W-1:0] res_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_at_acc;
    logic out_free;
  } status_t;

endpackage

@@ sv/dense_layer_matrix_vector_core.sv @@
// top level of the dense layer matrix-vector core
//
// Input channel (in_valid / in_stall): each word either writes one Q3.12
// weight (in_action = 0, row in_in_index, column in_out_index) or presents
// one Q7.8 element (in_action = 1). Every weight must be written before use.
// Writes and elements are taken one per cycle while in_stall is low; an
// element reaches the accumulators through the ram read and the product
// register, all outputs in parallel from one weight row read (one ram per
// output column). On an element with in_last set, in_stall rises: the
// element drains through the read and multiply stages, then OUT_COUNT
// sums (20 fraction bits) leave on the output channel in order of
// out_result_index, one per cycle, out_final_res marking the last. Input
// resumes when the final sum enters the output register. While out_stall
// is high the output word holds and the emission pauses. Reset clears
// the accumulators and flow control; weight contents are kept undefined
// until written.
module dense_layer_matrix_vector_core #(
  parameter int IN_COUNT  = 32,
  parameter int OUT_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [dlmv_pkg::ROW_IDX_W-1:0]      in_in_index,
  input  logic [dlmv_pkg::COL_IDX_W-1:0]      in_out_index,
  input  logic signed [dlmv_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dlmv_pkg::RES_IDX_W-1:0]      out_result_index,
  output logic signed [dlmv_pkg::SUM_W-1:0]   out_sum,
  output logic                                out_final_res
);
  import dlmv_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // control
  dlmv_ctrl #(
    .OUT_COUNT(OUT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_last  (in_last),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath
  dlmv_datapath #(
    .IN_COUNT (IN_COUNT),
    .OUT_COUNT(OUT_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_in_index     (in_in_index),
    .in_out_index    (in_out_index),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_index(out_result_index),
    .out_sum         (out_sum),
    .out_final_res   (out_final_res)
  );

endmodule

@@ sv/dlmv_ram.sv @@
// generic single-write, single-read ram with registered read data
module dlmv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

@@ sv/dlmv_ctrl.sv @@
// controller: input flow, drain of the last element and emission of sums
module dlmv_ctrl #(
  parameter int OUT_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  input  logic              in_last,
  output logic              in_stall,
  output dlmv_pkg::cmd_t    cmd,
  input  dlmv_pkg::status_t stat
);
  import dlmv_pkg::*;

  `include "dense_layer_matrix_vector_core_defines.svh"

  localparam int CW = (OUT_COUNT > 1) ? $clog2(OUT_COUNT) : 1;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          elem_last;

  // outputs of the state machine
  always_comb begin
    in_stall       = 1'b1;
    cmd.take       = 1'b0;
    cmd.shift      = 1'b0;
    cmd.final_word = (cnt_r == CW'(OUT_COUNT - 1));
    cmd.res_idx    = RES_IDX_W'(cnt_r);
    unique case (state_r)
      ST_RUN: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_DRAIN: begin
        in_stall = 1'b1;
      end
      ST_EMIT: begin
        cmd.shift = stat.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign elem_last = cmd.take && (in_action == ACT_ELEM) && in_last;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (elem_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.last_at_acc) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.shift && cmd.final_word) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // output word counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.shift) begin
      cnt_nxt = cmd.final_word ? '0 : cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `DLMV_ASSERT_NEXT(a_last_drains, elem_last, state_r == ST_DRAIN, "last element did not start drain")
  `DLMV_ASSERT_NEXT(a_drain_emits, (state_r == ST_DRAIN) && stat.last_at_acc, state_r == ST_EMIT, "drain did not lead to emit")
  `DLMV_ASSERT_NEXT(a_final_runs, cmd.shift && cmd.final_word, (state_r == ST_RUN) && (cnt_r == '0), "emit did not finish cleanly")

endmodule

@@ sv/dlmv_datapath.sv @@
// datapath: weight rams, per-output multipliers, accumulators, output register
module dlmv_datapath #(
  parameter int IN_COUNT  = 32,
  parameter int OUT_COUNT = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dlmv_pkg::cmd_t                         cmd,
  output dlmv_pkg::status_t                      stat,
  input  logic                                   in_action,
  input  logic [dlmv_pkg::ROW_IDX_W-1:0]         in_in_index,
  input  logic [dlmv_pkg::COL_IDX_W-1:0]         in_out_index,
  input  logic signed [dlmv_pkg::VALUE_W-1:0]    in_value,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [dlmv_pkg::RES_IDX_W-1:0]         out_result_index,
  output logic signed [dlmv_pkg::SUM_W-1:0]      out_sum,
  output logic                                   out_final_res
);
  import dlmv_pkg::*;

  `include "dense_layer_matrix_vector_core_defines.svh"

  localparam int AW = (IN_COUNT > 1) ? $clog2(IN_COUNT) : 1;

  logic                       row_ok, col_ok, wr, elem;
  logic [AW-1:0]              addr;
  logic [OUT_COUNT-1:0]       col_we;
  logic signed [VALUE_W-1:0]  rd [OUT_COUNT];

  logic                       v1_r, last1_r, inr1_r;
  logic signed [VALUE_W-1:0]  val1_r;
  logic                       v2_r, last2_r, inr2_r;
  logic signed [PROD_W-1:0]   prod_r [OUT_COUNT];
  logic signed [SUM_W-1:0]    acc_r [OUT_COUNT];

  logic                       out_valid_r;
  logic [RES_IDX_W-1:0]       out_idx_r;
  logic signed [SUM_W-1:0]    out_sum_r;
  logic                       out_final_r;

  // address decode and range checks
  assign row_ok = (9'(in_in_index) < 9'(IN_COUNT));
  assign col_ok = (7'(in_out_index) < 7'(OUT_COUNT));
  assign wr     = cmd.take && (in_action == ACT_WRITE) && row_ok && col_ok;
  assign elem   = cmd.take && (in_action == ACT_ELEM);
  assign addr   = AW'(in_in_index);

  // one weight ram per output column
  for (genvar o = 0; o < OUT_COUNT; o++) begin : g_col
    assign col_we[o] = wr && (7'(in_out_index) == 7'(o));

    dlmv_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(IN_COUNT)
    ) u_ram (
      .clk    (clk),
      .we     (col_we[o]),
      .waddr  (addr),
      .wdata  (in_value),
      .raddr  (addr),
      .rdata_r(rd[o])
    );
  end

  // stage control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= elem;
      v2_r <= v1_r;
    end
  end

  // stage payload: element value alongside the ram read, then products
  always_ff @(posedge clk) begin
    last1_r <= in_last;
    inr1_r  <= row_ok;
    val1_r  <= in_value;
    last2_r <= last1_r;
    inr2_r  <= inr1_r;
    for (int o = 0; o < OUT_COUNT; o++) begin
      prod_r[o] <= val1_r * rd[o];
    end
  end

  assign stat.last_at_acc = v2_r && last2_r;
  assign stat.out_free    = !out_valid_r || !out_stall;

  // accumulators: add products, or shift toward the output while emitting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int o = 0; o < OUT_COUNT; o++) begin
        acc_r[o] <= '0;
      end
    end else if (cmd.shift) begin
      for (int o = 0; o < OUT_COUNT - 1; o++) begin
        acc_r[o] <= acc_r[o + 1];
      end
      acc_r[OUT_COUNT - 1] <= '0;
    end else if (v2_r && inr2_r) begin
      for (int o = 0; o < OUT_COUNT; o++) begin
        acc_r[o] <= acc_r[o] + SUM_W'(prod_r[o]);
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.shift) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      out_idx_r   <= cmd.res_idx;
      out_sum_r   <= acc_r[0];
      out_final_r <= cmd.final_word;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_sum          = out_sum_r;
  assign out_final_res    = out_final_r;

  `DLMV_ASSERT_NEXT(a_shift_loads, cmd.shift, out_valid_r, "shifted word not presented")
  `DLMV_ASSERT_NEXT(a_acc_cleared, cmd.shift && cmd.final_word, acc_r[0] == '0, "accumulators not cleared after emit")
  `DLMV_ASSERT_NOW(a_no_add_on_shift, cmd.shift, !v2_r, "product arrived while emitting")

endmodule

@@ tb/sv/dense_layer_matrix_vector_core_tb.sv @@
// self-checking testbench for the dense layer matrix-vector core
module dense_layer_matrix_vector_core_tb;
  import dlmv_pkg::*;

  localparam int NUM_IN = 32;
  localparam int NUM_OUT = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PRINT_CAP = 40;

  // one expected output word
  typedef struct packed {
    logic [RES_IDX_W-1:0]    idx;
    logic signed [SUM_W-1:0] sum;
    logic                    is_last;
  } sum_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = ACT_WRITE;
  logic [ROW_IDX_W-1:0] in_in_index = '0;
  logic [COL_IDX_W-1:0] in_out_index = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RES_IDX_W-1:0] out_result_index;
  logic signed [SUM_W-1:0] out_sum;
  logic out_final_res;

  // predictor state: weight copy, running sums, sums still owed by the block
  logic signed [VALUE_W-1:0] weight_copy [NUM_IN*NUM_OUT];
  logic signed [SUM_W-1:0] neuron_sums [NUM_OUT];
  sum_word_t expected_sums [$];

  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int idle_cycles = 0;

  dense_layer_matrix_vector_core #(
    .IN_COUNT(NUM_IN),
    .OUT_COUNT(NUM_OUT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_in_index(in_in_index),
    .in_out_index(in_out_index),
    .in_value(in_value),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_index(out_result_index),
    .out_sum(out_sum),
    .out_final_res(out_final_res)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // update the predictor with one accepted word
  task automatic predict_word(input logic act, input int row, input int col,
                              input logic signed [VALUE_W-1:0] val,
                              input logic mark_last);
    logic signed [PROD_W-1:0] prod;
    sum_word_t word;
    if (act == ACT_WRITE) begin
      if (row < NUM_IN && col < NUM_OUT) begin
        weight_copy[row*NUM_OUT + col] = val;
      end
    end else begin
      // out-of-range rows add nothing but still honor the last mark
      if (row < NUM_IN) begin
        for (int o = 0; o < NUM_OUT; o++) begin
          prod = val * weight_copy[row*NUM_OUT + o];
          neuron_sums[o] = neuron_sums[o] + prod;
        end
      end
      if (mark_last) begin
        for (int o = 0; o < NUM_OUT; o++) begin
          word.idx = RES_IDX_W'(o);
          word.sum = neuron_sums[o];
          word.is_last = (o == NUM_OUT - 1);
          expected_sums.push_back(word);
          neuron_sums[o] = '0;
        end
      end
    end
  endtask

  // offer one word, wait for the handshake, then predict
  task automatic send_word(input logic act, input int row, input int col,
                           input logic signed [VALUE_W-1:0] val,
                           input logic mark_last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action <= act;
    in_in_index <= ROW_IDX_W'(row);
    in_out_index <= COL_IDX_W'(col);
    in_value <= val;
    in_last <= mark_last;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_word(act, row & ((1 << ROW_IDX_W) - 1), col & ((1 << COL_IDX_W) - 1),
                 val, mark_last);
  endtask

  // value with extra weight on the two extremes
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // check each output word against the oldest expected sum
  always @(posedge clk) begin : check_sums
    sum_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected sum word, index %0d sum %0d",
                                  out_result_index, out_sum));
      end else begin
        want = expected_sums.pop_front();
        if (out_result_index !== want.idx) begin
          report_mismatch($sformatf("result index %0d, want %0d",
                                    out_result_index, want.idx));
        end
        if (out_sum !== want.sum) begin
          report_mismatch($sformatf("sum %0d for index %0d, want %0d",
                                    out_sum, want.idx, want.sum));
        end
        if (out_final_res !== want.is_last) begin
          report_mismatch($sformatf("final flag %b for index %0d, want %b",
                                    out_final_res, want.idx, want.is_last));
        end
      end
    end
  end

  // fill the whole weight store so no element ever reads an unwritten entry
  task automatic test_weight_load();
    for (int r = 0; r < NUM_IN; r++) begin
      for (int c = 0; c < NUM_OUT; c++) begin
        send_word(ACT_WRITE, r, c, pick_value(), 1'b0);
      end
    end
  endtask

  // most negative and most positive operands on both sides
  task automatic test_extreme_products();
    send_word(ACT_WRITE, 31, 0, 16'sh8000, 1'b0);
    send_word(ACT_WRITE, 31, 1, 16'sh7fff, 1'b0);
    send_word(ACT_WRITE, 31, 2, 16'sh8000, 1'b1);
    send_word(ACT_WRITE, 31, 3, 16'sh0001, 1'b0);
    send_word(ACT_ELEM, 31, 3, 16'sh8000, 1'b0);
    send_word(ACT_ELEM, 31, 0, 16'sh7fff, 1'b1);
    send_word(ACT_ELEM, 31, 2, -16'sd1, 1'b1);
  endtask

  // last mark on a weight write is ignored, the next element still closes
  task automatic test_last_on_weight_write();
    send_word(ACT_WRITE, 5, 2, 16'sh1234, 1'b1);
    send_word(ACT_ELEM, 5, 1, 16'sh0100, 1'b1);
  endtask

  // the same element position presented several times accumulates each time
  task automatic test_repeated_element();
    send_word(ACT_ELEM, 7, 0, 16'sh0064, 1'b0);
    send_word(ACT_ELEM, 7, 3, 16'sh0064, 1'b0);
    send_word(ACT_ELEM, 7, 1, 16'sh0064, 1'b1);
  endtask

  // one-element vectors, zero value and then back-to-back closes
  task automatic test_single_element_vectors();
    send_word(ACT_ELEM, 0, 0, 16'sh0000, 1'b1);
    send_word(ACT_ELEM, 16, 1, 16'sh5555, 1'b1);
    send_word(ACT_ELEM, 15, 2, 16'shaaaa, 1'b1);
  endtask

  // element rows cannot leave the store at these sizes, so the
  // out-of-range cases are not reachable from the ports

  // mostly well-formed vectors with random content, some noise words
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_words);
    int sent;
    int kind;
    int len;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        len = ($urandom_range(11) == 0) ? NUM_IN : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(9) == 0) begin
            send_word(ACT_WRITE, $urandom_range(NUM_IN-1), $urandom_range(NUM_OUT-1),
                      pick_value(), 1'($urandom_range(1)));
            sent++;
          end
          send_word(ACT_ELEM, (len == NUM_IN) ? k : $urandom_range(NUM_IN-1),
                    $urandom_range(3), pick_value(), k == len - 1);
          sent++;
        end
      end else if (kind < 90) begin
        send_word(ACT_WRITE, $urandom_range(NUM_IN-1), $urandom_range(NUM_OUT-1),
                  pick_value(), 1'($urandom_range(1)));
        sent++;
      end else begin
        send_word(ACT_ELEM, $urandom_range(NUM_IN-1), $urandom_range(3),
                  pick_value(), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  // close any open vector so its sums are checked too
  task automatic test_flush_vector();
    send_word(ACT_ELEM, $urandom_range(NUM_IN-1), 0, pick_value(), 1'b1);
  endtask

  // run sequence
  initial begin
    for (int o = 0; o < NUM_OUT; o++) neuron_sums[o] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_weight_load();
    test_extreme_products();
    test_last_on_weight_write();
    test_repeated_element();
    test_single_element_vectors();
    test_random_traffic(0, 0, 20);
    test_random_traffic(87, 0, 20);
    test_random_traffic(0, 87, 20);
    test_random_traffic(24, 24, 20);
    test_flush_vector();
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
